[rtl/rbs_pkg.sv]
`default_nettype none
package rbs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Reset value of the half box height along y, about 0.05 in Q16.16.
	localparam int HALF_THICK_RESET = 3277;

	// Slab distances are kept as signed 64 bit values whose magnitude saturates.
	localparam int T_WIDTH = 64;
	localparam int T_MAG_WIDTH = 62;
	localparam logic [T_WIDTH-1:0] T_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

endpackage
`default_nettype wire

[rtl/rbs_if.sv]
`default_nettype none

interface rbs_ray_if
	import rbs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] origin_x;
	logic signed [COORD_WIDTH-1:0] origin_y;
	logic signed [COORD_WIDTH-1:0] origin_z;
	logic signed [FRAC_BITS+1:0] dir_x;
	logic signed [FRAC_BITS+1:0] dir_y;
	logic signed [FRAC_BITS+1:0] dir_z;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic [COORD_WIDTH-2:0] extent_x;
	logic [COORD_WIDTH-2:0] extent_z;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output center_x, center_y, center_z, extent_x, extent_z,
		input ready
	);
	modport sink (
		input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input center_x, center_y, center_z, extent_x, extent_z,
		output ready
	);
endinterface

interface rbs_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

interface rbs_cfg_if
	import rbs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic [COORD_WIDTH-2:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/ray_box_slab_intersect_top.sv]
// Ray against axis-aligned box slab test, one test per transaction.
// The ray channel carries origin, direction, box center and the x and z
// extents; the result channel returns one hit bit per ray, in order.
// The cfg channel writes the half box height along y; it is always ready
// and should only be written while no ray is in flight.
// Throughput is one ray per cycle while the result side is not stalled.
// The six slab divisions are restoring dividers that produce one quotient
// bit per pipeline stage; they set the depth.
// The whole pipeline moves on a common enable: while a result is held
// because the receiver is not ready, nothing advances and the ray channel
// is not ready. While the last stage is empty the pipeline advances even
// if the receiver is not ready.
// Reset empties the pipeline and sets the half height to about 0.05.
`default_nettype none
module ray_box_slab_intersect_top
	import rbs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rbs_ray_if.sink ray,
	rbs_hit_if.source result,
	rbs_cfg_if.sink cfg
);

	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int DW = FB + 2;
	localparam int SW = CW + 3;
	localparam int MW = CW + 2;
	localparam int NW = MW + FB - 1;
	localparam int S = NW + 6;
	localparam int QX = (NW > 63) ? NW : 63;

	typedef struct packed {
		logic ok;
		logic open;
		logic signed [T_WIDTH-1:0] tlo;
		logic signed [T_WIDTH-1:0] thi;
	} ivl_t;

	function automatic ivl_t narrow_ivl(ivl_t s, logic par, logic pok,
			logic signed [T_WIDTH-1:0] a, logic signed [T_WIDTH-1:0] b);
		ivl_t n;
		n = s;
		priority if (!s.ok) begin
			n = s;
		end else if (par) begin
			n.ok = pok;
		end else if (s.open) begin
			n.open = 1'b0;
			n.tlo = a;
			n.thi = b;
		end else if (s.tlo > b || a > s.thi) begin
			n.ok = 1'b0;
		end else begin
			if (a > s.tlo) n.tlo = a;
			if (b < s.thi) n.thi = b;
		end
		return n;
	endfunction

	logic [CW-2:0] half_thick_q;
	logic [S-1:0] vld_q;
	logic en;

	assign en = !vld_q[S-1] || result.ready;
	assign ray.ready = en;
	assign cfg.ready = 1'b1;
	assign result.valid = vld_q[S-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_thick_q <= (CW-1)'(HALF_THICK_RESET);
		end else if (cfg.valid) begin
			half_thick_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[S-2:0], ray.valid};
		end
	end

	// Stage 1: slab numerators at twice scale, their magnitudes and signs.
	logic signed [CW-1:0] org [3];
	logic signed [CW-1:0] ctr [3];
	logic signed [DW-1:0] dir [3];
	logic [CW-1:0] ext2 [3];

	always_comb begin
		org[0] = ray.origin_x;
		org[1] = ray.origin_y;
		org[2] = ray.origin_z;
		ctr[0] = ray.center_x;
		ctr[1] = ray.center_y;
		ctr[2] = ray.center_z;
		dir[0] = ray.dir_x;
		dir[1] = ray.dir_y;
		dir[2] = ray.dir_z;
		ext2[0] = {1'b0, ray.extent_x};
		ext2[1] = {half_thick_q, 1'b0};
		ext2[2] = {1'b0, ray.extent_z};
	end

	logic [5:0][NW-1:0] nq_s1;
	logic [5:0] neg_s1;
	logic [2:0][DW-1:0] dm_s1;
	logic [2:0] par_s1;
	logic [2:0] pok_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [SW-1:0] c2, o2, nlo, nhi;
				c2 = SW'(ctr[a]) <<< 1;
				o2 = SW'(org[a]) <<< 1;
				nlo = c2 - $signed(SW'(ext2[a])) - o2;
				nhi = c2 + $signed(SW'(ext2[a])) - o2;
				nq_s1[2*a] <= {MW'(nlo[SW-1] ? -nlo : nlo), {(FB-1){1'b0}}};
				nq_s1[2*a+1] <= {MW'(nhi[SW-1] ? -nhi : nhi), {(FB-1){1'b0}}};
				neg_s1[2*a] <= nlo[SW-1] ^ dir[a][DW-1];
				neg_s1[2*a+1] <= nhi[SW-1] ^ dir[a][DW-1];
				dm_s1[a] <= dir[a][DW-1] ? DW'(-dir[a]) : DW'(dir[a]);
				par_s1[a] <= (dir[a] == '0);
				pok_s1[a] <= (nlo[SW-1] || nlo == '0) && !nhi[SW-1];
			end
		end
	end

	// Division stages: each one shifts in one numerator bit and decides one
	// quotient bit for all six slab distances.
	logic [5:0][DW-1:0] dv_r_s2 [NW];
	logic [5:0][NW-1:0] dv_nq_s2 [NW];
	logic [5:0] dv_neg_s2 [NW];
	logic [2:0][DW-1:0] dv_dm_s2 [NW];
	logic [2:0] dv_par_s2 [NW];
	logic [2:0] dv_pok_s2 [NW];

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [5:0][DW-1:0] r_in;
		logic [5:0][NW-1:0] nq_in;
		logic [5:0] neg_in;
		logic [2:0][DW-1:0] dm_in;
		logic [2:0] par_in;
		logic [2:0] pok_in;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign nq_in = nq_s1;
			assign neg_in = neg_s1;
			assign dm_in = dm_s1;
			assign par_in = par_s1;
			assign pok_in = pok_s1;
		end else begin : g_next
			assign r_in = dv_r_s2[k-1];
			assign nq_in = dv_nq_s2[k-1];
			assign neg_in = dv_neg_s2[k-1];
			assign dm_in = dv_dm_s2[k-1];
			assign par_in = dv_par_s2[k-1];
			assign pok_in = dv_pok_s2[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 6; l++) begin
					logic [DW:0] tr;
					logic ge;
					tr = {r_in[l], nq_in[l][NW-1]};
					ge = tr >= {1'b0, dm_in[l/2]};
					dv_r_s2[k][l] <= ge ? DW'(tr - {1'b0, dm_in[l/2]}) : DW'(tr);
					dv_nq_s2[k][l] <= {nq_in[l][NW-2:0], ge};
				end
				dv_neg_s2[k] <= neg_in;
				dv_dm_s2[k] <= dm_in;
				dv_par_s2[k] <= par_in;
				dv_pok_s2[k] <= pok_in;
			end
		end
	end

	// Saturate and sign the quotients.
	logic signed [5:0][T_WIDTH-1:0] t_s3;
	logic [2:0] par_s3;
	logic [2:0] pok_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 6; l++) begin
				logic [QX-1:0] qx;
				logic [T_MAG_WIDTH-1:0] mag;
				logic signed [T_WIDTH-1:0] tv;
				qx = QX'(dv_nq_s2[NW-1][l]);
				mag = (qx > QX'(T_LIMIT)) ? T_LIMIT[T_MAG_WIDTH-1:0]
					: qx[T_MAG_WIDTH-1:0];
				tv = $signed({2'b00, mag});
				t_s3[l] <= dv_neg_s2[NW-1][l] ? -tv : tv;
			end
			par_s3 <= dv_par_s2[NW-1];
			pok_s3 <= dv_pok_s2[NW-1];
		end
	end

	// Order each entry and exit pair.
	logic signed [2:0][T_WIDTH-1:0] lo_s4;
	logic signed [2:0][T_WIDTH-1:0] hi_s4;
	logic [2:0] par_s4;
	logic [2:0] pok_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				if ($signed(t_s3[2*a]) > $signed(t_s3[2*a+1])) begin
					lo_s4[a] <= t_s3[2*a+1];
					hi_s4[a] <= t_s3[2*a];
				end else begin
					lo_s4[a] <= t_s3[2*a];
					hi_s4[a] <= t_s3[2*a+1];
				end
			end
			par_s4 <= par_s3;
			pok_s4 <= pok_s3;
		end
	end

	// Narrow the interval with x and y, then with z.
	ivl_t ivl_init;
	ivl_t ivl_x;
	ivl_t xy_s5;
	ivl_t z_s6;
	logic signed [T_WIDTH-1:0] lo_z_s5;
	logic signed [T_WIDTH-1:0] hi_z_s5;
	logic par_z_s5;
	logic pok_z_s5;
	logic hit_s7;

	always_comb begin
		ivl_init.ok = 1'b1;
		ivl_init.open = 1'b1;
		ivl_init.tlo = '0;
		ivl_init.thi = '0;
		ivl_x = narrow_ivl(ivl_init, par_s4[0], pok_s4[0], lo_s4[0], hi_s4[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s5 <= narrow_ivl(ivl_x, par_s4[1], pok_s4[1], lo_s4[1], hi_s4[1]);
			lo_z_s5 <= lo_s4[2];
			hi_z_s5 <= hi_s4[2];
			par_z_s5 <= par_s4[2];
			pok_z_s5 <= pok_s4[2];
			z_s6 <= narrow_ivl(xy_s5, par_z_s5, pok_z_s5, lo_z_s5, hi_z_s5);
			// With every slab parallel the exit distance is unbounded.
			hit_s7 <= z_s6.ok && (z_s6.open || z_s6.thi > 0);
		end
	end

	assign result.hit = hit_s7;

endmodule
`default_nettype wire

[sim/rbs_tb_pkg.sv]
package rbs_tb_pkg;

	// One ray test as sent on the ray channel.
	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic signed [17:0] dir_z;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0] extent_x;
		logic [30:0] extent_z;
	} ray_item_t;

endpackage

[sim/testbench.sv]
module testbench;
	import rbs_pkg::*;
	import rbs_tb_pkg::*;

	localparam logic signed [63:0] T_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int LATENCY = 55;
	localparam int N_RANDOM = 1230;
	localparam int N_DIRECTED = 14;
	localparam logic [30:0] HT_MAX = 31'h7FFF_FFFF;
	localparam logic [30:0] HT_ONE = 31'h0001_0000;
	// Value meaning "check against the predictor" in the directed table.
	localparam int EXP_PREDICT = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbs_ray_if ray();
	rbs_hit_if result();
	rbs_cfg_if cfg();

	ray_box_slab_intersect_top DUT (
		.clk(clk), .arst_n(arst_n), .ray(ray), .result(result), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [30:0] half_height;
	bit hit_queue[$];
	int mismatches = 0;
	int hits_seen = 0;
	bit sender_quiet = 1'b0;
	bit hold_off = 1'b0;
	bit no_idle = 1'b0;

	// Slab distance num2 * 2^15 / d, truncated toward zero, saturated.
	function automatic logic signed [63:0] slab_time(logic signed [63:0] num2,
			logic signed [63:0] d);
		logic [63:0] n, dm, q, r;
		int i;
		n = num2 < 0 ? -num2 : num2;
		dm = d < 0 ? -d : d;
		q = n / dm;
		r = n % dm;
		for (i = 0; i < 15; i++) begin
			if (q > (T_MAX >> 1)) begin
				q = T_MAX;
				break;
			end
			r = r << 1;
			q = q << 1;
			if (r >= dm) begin
				r = r - dm;
				q[0] = 1'b1;
			end
		end
		if (q > T_MAX)
			q = T_MAX;
		if ((num2 < 0) != (d < 0))
			return -$signed(q);
		return $signed(q);
	endfunction

	function automatic bit slab_narrow(logic signed [63:0] org, logic signed [63:0] dir,
			logic signed [63:0] ctr, logic signed [63:0] ext2, ref bit open,
			ref logic signed [63:0] t_in, ref logic signed [63:0] t_out);
		logic signed [63:0] lo2, hi2, a, b, s;
		lo2 = 2 * ctr - ext2;
		hi2 = 2 * ctr + ext2;
		if (dir == 0)
			return lo2 <= 2 * org && 2 * org <= hi2;
		a = slab_time(lo2 - 2 * org, dir);
		b = slab_time(hi2 - 2 * org, dir);
		if (a > b) begin
			s = a;
			a = b;
			b = s;
		end
		if (open) begin
			open = 1'b0;
			t_in = a;
			t_out = b;
			return 1'b1;
		end
		if (t_in > b || a > t_out)
			return 1'b0;
		if (a > t_in)
			t_in = a;
		if (b < t_out)
			t_out = b;
		return 1'b1;
	endfunction

	function automatic bit predict_hit(ray_item_t r);
		bit open;
		bit ok;
		logic signed [63:0] t_in, t_out;
		open = 1'b1;
		t_in = 0;
		t_out = 0;
		ok = slab_narrow(r.origin_x, r.dir_x, r.center_x, {33'b0, r.extent_x}, open, t_in,
				t_out)
			&& slab_narrow(r.origin_y, r.dir_y, r.center_y, {32'b0, half_height, 1'b0},
				open, t_in, t_out)
			&& slab_narrow(r.origin_z, r.dir_z, r.center_z, {33'b0, r.extent_z}, open, t_in,
				t_out);
		// With every slab parallel the exit distance is unbounded.
		if (ok && !open)
			ok = t_out > 0;
		return ok;
	endfunction

	function automatic ray_item_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
			int cx, int cy, int cz, int ex, int ez);
		ray_item_t r;
		r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
		r.dir_x = 18'(dx); r.dir_y = 18'(dy); r.dir_z = 18'(dz);
		r.center_x = cx; r.center_y = cy; r.center_z = cz;
		r.extent_x = 31'(ex); r.extent_z = 31'(ez);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic logic signed [17:0] rand_dir();
		case ($urandom_range(0, 5))
			0: return 18'sd0;
			1: return 18'($urandom());
			2: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
			default: return 18'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	function automatic logic [30:0] rand_extent();
		case ($urandom_range(0, 3))
			0: return 31'($urandom());
			1: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
			default: return 31'($urandom_range(0, 32'h0004_0000));
		endcase
	endfunction

	// Mostly rays aimed near the box so that many of them hit.
	function automatic ray_item_t rand_ray();
		ray_item_t r;
		r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
		r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
		r.extent_x = rand_extent(); r.extent_z = rand_extent();
		if ($urandom_range(0, 99) < 70) begin
			r.center_x = r.origin_x + (r.dir_x <<< 2) + $signed($urandom_range(0, 4095)) - 2048;
			r.center_y = r.origin_y + (r.dir_y <<< 2) + $signed($urandom_range(0, 4095)) - 2048;
			r.center_z = r.origin_z + (r.dir_z <<< 2) + $signed($urandom_range(0, 4095)) - 2048;
		end else begin
			r.center_x = rand_coord(); r.center_y = rand_coord(); r.center_z = rand_coord();
		end
		return r;
	endfunction

	task automatic write_half_height(logic [30:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		half_height = value;
	endtask

	task automatic drain();
		while (hit_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_ray(ray_item_t r, int expected);
		while (!no_idle && $urandom_range(0, 99) < 34) begin
			ray.valid <= 1'b0;
			@(posedge clk);
		end
		{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z,
			ray.center_x, ray.center_y, ray.center_z, ray.extent_x, ray.extent_z} <= r;
		ray.valid <= 1'b1;
		@(posedge clk);
		while (!ray.ready)
			@(posedge clk);
		if (expected != EXP_PREDICT && expected != predict_hit(r))
			$display("directed row expectation disagrees with prediction");
		hit_queue.push_back(expected == EXP_PREDICT ? predict_hit(r) : expected[0]);
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				result.ready <= 1'b0;
				for (stall = 0; stall < 200; stall++)
					@(posedge clk);
				hold_off = 1'b0;
			end
			result.ready <= no_idle || $urandom_range(0, 99) >= 34;
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (hit_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: hit=%0b", result.hit);
				end else begin
					bit want;
					want = hit_queue.pop_front();
					hits_seen += result.hit;
					if (result.hit !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("hit mismatch: expected %0b, actual %0b", want, result.hit);
					end
				end
			end
		end
	end

	initial begin
		ray_item_t rows[N_DIRECTED];
		int expect_row[N_DIRECTED];
		logic [30:0] settings[4];
		int i, k;
		ray.valid <= 1'b0;
		{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z,
			ray.center_x, ray.center_y, ray.center_z, ray.extent_x, ray.extent_z} <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		half_height = 31'(HALF_THICK_RESET);

		// Ray along +x towards a unit box at x=4; after reset the y slab is thin.
		rows[0] = make_ray(0, 0, 0, 65536, 0, 0, 262144, 0, 0, 65536, 65536);
		expect_row[0] = 1;
		// Box behind the origin.
		rows[1] = make_ray(0, 0, 0, 65536, 0, 0, -262144, 0, 0, 65536, 65536);
		expect_row[1] = 0;
		// All directions zero, origin inside: unbounded exit counts as hit.
		rows[2] = make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 65536);
		expect_row[2] = 1;
		// All directions zero, origin outside in z.
		rows[3] = make_ray(0, 0, 262144, 0, 0, 0, 0, 0, 0, 65536, 65536);
		expect_row[3] = 0;
		// Parallel in y with the origin exactly on the inclusive upper bound.
		rows[4] = make_ray(0, 3277, 0, 65536, 0, 0, 262144, 0, 0, 65536, 65536);
		expect_row[4] = 1;
		// Parallel in y just above the bound.
		rows[5] = make_ray(0, 3278, 0, 65536, 0, 0, 262144, 0, 0, 65536, 65536);
		expect_row[5] = 0;
		// Origin on the far face: exit distance zero is not a hit.
		rows[6] = make_ray(294912, 0, 0, 65536, 0, 0, 262144, 0, 0, 65536, 65536);
		expect_row[6] = 0;
		// Zero-width box touching the ray: entry equals exit.
		rows[7] = make_ray(0, 0, 0, 65536, 0, 0, 262144, 0, 0, 0, 65536);
		expect_row[7] = 1;
		// Extremes of coordinates, directions and extents.
		rows[8] = make_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -65536, 65536, 1,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		expect_row[8] = EXP_PREDICT;
		rows[9] = make_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 18'h1FFFF, 18'h20000,
				-1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		expect_row[9] = EXP_PREDICT;
		rows[10] = make_ray(0, 0, 0, 1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'h7FFF_FFFF);
		expect_row[10] = EXP_PREDICT;
		// Diagonal ray through a box, and one that misses past the corner.
		rows[11] = make_ray(0, 0, 0, 46341, 46341, 46341, 196608, 196608, 196608,
				131072, 131072);
		expect_row[11] = EXP_PREDICT;
		rows[12] = make_ray(0, 0, 0, 65536, 0, 6554, 262144, 0, 262144, 65536, 65536);
		expect_row[12] = EXP_PREDICT;
		rows[13] = make_ray(-262144, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, 65536);
		expect_row[13] = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++)
			send_ray(rows[i], expect_row[i]);
		ray.valid <= 1'b0;
		drain();

		settings[0] = HT_MAX;
		settings[1] = 31'h0;
		settings[2] = HT_ONE;
		settings[3] = 31'($urandom());
		for (k = 0; k < 4; k++) begin
			write_half_height(settings[k]);
			for (i = 0; i < N_RANDOM / 4; i++) begin
				no_idle = (k == 2 && i < 120);
				if (k == 1 && i == 50)
					hold_off = 1'b1;
				if (k == 3 && i == 100) begin
					// Sender waits until every expected result is back.
					ray.valid <= 1'b0;
					while (hit_queue.size() != 0)
						@(posedge clk);
				end
				send_ray(rand_ray(), EXP_PREDICT);
			end
			no_idle = 1'b0;
			ray.valid <= 1'b0;
			drain();
		end

		if (mismatches == 0 && hit_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule
